// ===== src/conv3x3_zero_padded_defines.svh =====
// ---------------------------------------------------------------------------
// conv3x3_zero_padded assertion macros
// Shorthand for the clocked, reset-gated checks of the convolution block.
// ---------------------------------------------------------------------------
`ifndef CONV3X3_ZERO_PADDED_DEFINES_SVH
`define CONV3X3_ZERO_PADDED_DEFINES_SVH

// cond must hold at every edge out of reset
`define C3Z_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// cons must hold at every edge where ante holds
`define C3Z_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/c3z_pkg.sv =====
// ---------------------------------------------------------------------------
// c3z_pkg
// Types, sizes and register codes shared by the 3x3 convolution block.
// ---------------------------------------------------------------------------
package c3z_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COEF_BITS  = 8;

    localparam int PIX_W      = 8;
    localparam int DIM_W      = 11;
    localparam int KROW_W     = 24;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int PROD_W     = COEF_BITS + PIX_W;
    localparam int RSUM_W     = PROD_W + 2;
    localparam int SUM_W      = PROD_W + 5;
    localparam int FILT_W     = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic signed [SUM_W-1:0] FILT_MAX = SUM_W'(2 ** (FILT_W - 1) - 1);
    localparam logic signed [SUM_W-1:0] FILT_MIN = SUM_W'(-(2 ** (FILT_W - 1)));

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KROW_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KROW_MID     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KROW_BOTTOM  = 3'd4;

    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = DIM_W'(1024);
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = DIM_W'(1024);
    localparam logic [KROW_W-1:0] RST_KROW_TOP     = 24'h00FF00;
    localparam logic [KROW_W-1:0] RST_KROW_MID     = 24'hFF04FF;
    localparam logic [KROW_W-1:0] RST_KROW_BOTTOM  = 24'h00FF00;

    localparam logic REQ_PIXEL = 1'b0;

    typedef struct packed {
        logic             req_type;
        logic [PIX_W-1:0] pixel;
    } t_in_beat;

    typedef struct packed {
        logic signed [FILT_W-1:0] filtered;
        logic                     end_of_row;
        logic                     end_of_frame;
    } t_out_beat;

    // per-item control carried down the pipeline
    typedef struct packed {
        logic started;
        logic eor;
        logic eof;
        logic zero_top;
        logic zero_bot;
        logic zero_left;
        logic zero_right;
    } t_flags;

endpackage

// ===== src/conv3x3_zero_padded.sv =====
// ---------------------------------------------------------------------------
// conv3x3_zero_padded
// Streaming 3x3 convolution of 8-bit pixels with signed coefficients,
// zero padding at the frame border.
// ---------------------------------------------------------------------------
// Usage:
//   Input beats carry one raster-order pixel (or a drain tick) each. After
//   the last pixel of a frame send frame_width+1 drain ticks to flush the
//   last row. The result for pixel (r,c) leaves with the beat that carries
//   pixel (r+1,c+1), flagged end_of_row / end_of_frame.
//   One input beat per clock is taken while o_in_stall is low; the rate is
//   set by the single read and write port of each line store and the
//   nine-tap cell row. Pipeline: line read, window shift, products, row
//   sums, then the result register that drives o_out_valid.
//   Output side: a result register plus one skid entry. When the receiver
//   stalls, the pipeline freezes only once the skid entry fills, and then
//   o_in_stall rises; it depends on no input combinationally.
//   Config: o_cfg_ready is always high. Write only while the block is idle;
//   a write to frame_width or frame_height restarts the frame.
//   Reset (synchronous, active low) restores the Laplacian kernel and a
//   1024x1024 frame; line store contents are kept and need no clearing.
// ---------------------------------------------------------------------------
`include "conv3x3_zero_padded_defines.svh"

module conv3x3_zero_padded (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  c3z_pkg::t_in_beat              i_in_beat,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output c3z_pkg::t_out_beat             o_out_beat,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [c3z_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [c3z_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int COL_W  = c3z_pkg::COL_W;
    localparam int ROW_W  = c3z_pkg::ROW_W;
    localparam int DIM_W  = c3z_pkg::DIM_W;
    localparam int PIX_W  = c3z_pkg::PIX_W;
    localparam int CB     = c3z_pkg::COEF_BITS;
    localparam int PROD_W = c3z_pkg::PROD_W;
    localparam int RSUM_W = c3z_pkg::RSUM_W;
    localparam int SUM_W  = c3z_pkg::SUM_W;
    localparam int FILT_W = c3z_pkg::FILT_W;

    // ---------------- configuration ----------------
    logic [DIM_W-1:0]           r_width;
    logic [DIM_W-1:0]           r_height;
    logic [c3z_pkg::KROW_W-1:0] r_krow [3];
    logic                       cfg_wr;
    logic                       cfg_restart;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign cfg_restart = cfg_wr && ((i_cfg_index == c3z_pkg::REG_FRAME_WIDTH) ||
                                    (i_cfg_index == c3z_pkg::REG_FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= c3z_pkg::RST_FRAME_WIDTH;
            r_height  <= c3z_pkg::RST_FRAME_HEIGHT;
            r_krow[0] <= c3z_pkg::RST_KROW_TOP;
            r_krow[1] <= c3z_pkg::RST_KROW_MID;
            r_krow[2] <= c3z_pkg::RST_KROW_BOTTOM;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                c3z_pkg::REG_FRAME_WIDTH:  r_width   <= i_cfg_data[DIM_W-1:0];
                c3z_pkg::REG_FRAME_HEIGHT: r_height  <= i_cfg_data[DIM_W-1:0];
                c3z_pkg::REG_KROW_TOP:     r_krow[0] <= i_cfg_data;
                c3z_pkg::REG_KROW_MID:     r_krow[1] <= i_cfg_data;
                c3z_pkg::REG_KROW_BOTTOM:  r_krow[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped geometry, minus one
    logic [DIM_W-1:0] w_lim, h_lim, w_dec, h_dec;
    logic [COL_W-1:0] w_m1;
    logic [ROW_W-1:0] h_m1;

    always_comb begin
        if (r_width == '0) begin
            w_lim = DIM_W'(1);
        end else if (r_width > DIM_W'(c3z_pkg::MAX_WIDTH)) begin
            w_lim = DIM_W'(c3z_pkg::MAX_WIDTH);
        end else begin
            w_lim = r_width;
        end
        if (r_height == '0) begin
            h_lim = DIM_W'(1);
        end else if (r_height > DIM_W'(c3z_pkg::MAX_HEIGHT)) begin
            h_lim = DIM_W'(c3z_pkg::MAX_HEIGHT);
        end else begin
            h_lim = r_height;
        end
        w_dec = w_lim - DIM_W'(1);
        h_dec = h_lim - DIM_W'(1);
        w_m1  = w_dec[COL_W-1:0];
        h_m1  = h_dec[ROW_W-1:0];
    end

    // ---------------- stream position ----------------
    logic             r_skid_valid;
    logic             pipe_en;
    logic             in_accept;
    logic [COL_W-1:0] r_in_col,  n_in_col;
    logic [1:0]       r_in_row,  n_in_row;   // saturates at two
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;
    c3z_pkg::t_flags  cur_flags;

    assign pipe_en    = !r_skid_valid;
    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !r_skid_valid;

    always_comb begin
        cur_flags.started    = (r_in_row == 2'd2) || ((r_in_row == 2'd1) && (r_in_col != '0));
        cur_flags.eor        = r_out_col >= w_m1;
        cur_flags.eof        = cur_flags.eor && (r_out_row >= h_m1);
        cur_flags.zero_top   = r_out_row == '0;
        cur_flags.zero_bot   = r_out_row >= h_m1;
        cur_flags.zero_left  = r_out_col == '0;
        cur_flags.zero_right = cur_flags.eor;

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (cfg_restart || (in_accept && cur_flags.started && cur_flags.eof)) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (in_accept) begin
            if (cur_flags.started) begin
                if (cur_flags.eor) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + ROW_W'(1);
                end else begin
                    n_out_col = r_out_col + COL_W'(1);
                end
            end
            if (r_in_col >= w_m1) begin
                n_in_col = '0;
                n_in_row = (r_in_row == 2'd2) ? 2'd2 : r_in_row + 2'd1;
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // ---------------- stage 1: line store read ----------------
    logic             r_s1_valid;
    c3z_pkg::t_flags  r_s1_flags;
    logic [PIX_W-1:0] r_s1_pix;
    logic [COL_W-1:0] r_s1_addr;
    logic [PIX_W-1:0] one_rd, two_rd;
    logic [PIX_W-1:0] in_pix;
    logic             s1_move;

    assign in_pix  = (i_in_beat.req_type == c3z_pkg::REQ_PIXEL) ? i_in_beat.pixel : '0;
    assign s1_move = pipe_en && r_s1_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (pipe_en) begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_flags <= cur_flags;
            r_s1_pix   <= in_pix;
            r_s1_addr  <= r_in_col;
        end
    end

    c3z_line_store u_lines (
        .i_clk         (i_clk),
        .i_rd_en       (in_accept),
        .i_rd_addr     (r_in_col),
        .i_one_wr_data (in_pix),
        .i_two_wr_en   (s1_move),
        .i_two_wr_addr (r_s1_addr),
        .o_one_rd      (one_rd),
        .o_two_rd      (two_rd)
    );

    // ---------------- stage 2/3: window shift, products ----------------
    logic            r_s2_valid, r_s3_valid, r_s4_valid;
    c3z_pkg::t_flags r_s2_flags, r_s3_flags, r_s4_flags;
    logic            s2_move;

    assign s2_move = pipe_en && r_s2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (pipe_en) begin
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_flags <= r_s1_flags;
        end
        if (s2_move) begin
            r_s3_flags <= r_s2_flags;
        end
        if (pipe_en && r_s3_valid) begin
            r_s4_flags <= r_s3_flags;
        end
    end

    logic [PIX_W-1:0]         col_in [3];
    logic [PIX_W-1:0]         tap_pix [3][3];
    logic signed [PROD_W-1:0] tap_prod [3][3];
    logic                     tap_zero [3][3];

    assign col_in[0] = two_rd;
    assign col_in[1] = one_rd;
    assign col_in[2] = r_s1_pix;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                tap_zero[i][j] = ((i == 0) && r_s2_flags.zero_top)  ||
                                 ((i == 2) && r_s2_flags.zero_bot)  ||
                                 ((j == 0) && r_s2_flags.zero_left) ||
                                 ((j == 2) && r_s2_flags.zero_right);
            end
        end
    end

    // column 2 takes the newest pixel; each tap hands its pixel left
    for (genvar gi = 0; gi < 3; gi++) begin : g_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_col
            logic [PIX_W-1:0] feed;
            if (gj == 2) begin : g_head
                assign feed = col_in[gi];
            end else begin : g_link
                assign feed = tap_pix[gi][gj+1];
            end
            c3z_tap_cell u_tap (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (s1_move),
                .i_pix   (feed),
                .i_calc  (s2_move),
                .i_zero  (tap_zero[gi][gj]),
                .i_coef  (r_krow[gi][gj*CB +: CB]),
                .o_pix   (tap_pix[gi][gj]),
                .o_prod  (tap_prod[gi][gj])
            );
        end
    end

    // ---------------- stage 4: row sums ----------------
    logic signed [RSUM_W-1:0] r_rsum [3];

    always_ff @(posedge i_clk) begin
        if (pipe_en && r_s3_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_rsum[i] <= RSUM_W'(tap_prod[i][0]) + RSUM_W'(tap_prod[i][1]) +
                             RSUM_W'(tap_prod[i][2]);
            end
        end
    end

    // ---------------- final add, saturate, output ----------------
    logic signed [SUM_W-1:0] total;
    c3z_pkg::t_out_beat      res;
    logic                    res_valid;

    always_comb begin
        total = SUM_W'(r_rsum[0]) + SUM_W'(r_rsum[1]) + SUM_W'(r_rsum[2]);
        if (total > c3z_pkg::FILT_MAX) begin
            res.filtered = c3z_pkg::FILT_MAX[FILT_W-1:0];
        end else if (total < c3z_pkg::FILT_MIN) begin
            res.filtered = c3z_pkg::FILT_MIN[FILT_W-1:0];
        end else begin
            res.filtered = total[FILT_W-1:0];
        end
        res.end_of_row   = r_s4_flags.eor;
        res.end_of_frame = r_s4_flags.eof;
        res_valid        = r_s4_valid && r_s4_flags.started;
    end

    logic               r_out_valid;
    c3z_pkg::t_out_beat r_out_beat;
    c3z_pkg::t_out_beat r_skid_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_skid_valid) begin
            if (!r_out_valid || !i_out_stall) begin
                r_out_valid <= res_valid;
            end else if (res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end else if (!i_out_stall) begin
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            if (!r_out_valid || !i_out_stall) begin
                r_out_beat <= res;
            end else if (res_valid) begin
                r_skid_beat <= res;
            end
        end else if (!i_out_stall) begin
            r_out_beat <= r_skid_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // ---------------- checks ----------------
    `C3Z_ASSERT_IMPLIES(a_skid_behind_out, r_skid_valid, r_out_valid, "skid beat without output beat")
    `C3Z_ASSERT_IMPLIES(a_skid_on_stall, r_skid_valid, $past(r_out_valid && i_out_stall), "skid filled without stall")
    `C3Z_ASSERT_IMPLIES(a_eof_is_eor, o_out_valid && o_out_beat.end_of_frame, o_out_beat.end_of_row, "frame end off row end")
    `C3Z_ASSERT_HOLDS(a_cols_in_frame, (r_out_col <= w_m1) && (r_in_col <= w_m1), "column counter past row width")

endmodule

// ===== src/c3z_line_store.sv =====
// ---------------------------------------------------------------------------
// c3z_line_store
// The two row buffers: pixels one and two rows above the input column.
// ---------------------------------------------------------------------------
module c3z_line_store (
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic [c3z_pkg::COL_W-1:0] i_rd_addr,
    input  logic [c3z_pkg::PIX_W-1:0] i_one_wr_data,
    input  logic                      i_two_wr_en,
    input  logic [c3z_pkg::COL_W-1:0] i_two_wr_addr,
    output logic [c3z_pkg::PIX_W-1:0] o_one_rd,
    output logic [c3z_pkg::PIX_W-1:0] o_two_rd
);

    logic [c3z_pkg::PIX_W-1:0] r_one_mem [c3z_pkg::MAX_WIDTH];
    logic [c3z_pkg::PIX_W-1:0] r_two_mem [c3z_pkg::MAX_WIDTH];
    logic [c3z_pkg::PIX_W-1:0] r_one_rd;
    logic [c3z_pkg::PIX_W-1:0] r_two_rd;

    // line one: read old value, write new pixel at the same column
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_one_rd             <= r_one_mem[i_rd_addr];
            r_one_mem[i_rd_addr] <= i_one_wr_data;
        end
    end

    // line two takes line one's old value from the read register when stage 1
    // moves on; bypass when the same column is read back at once (one-pixel rows)
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_two_wr_en && (i_two_wr_addr == i_rd_addr)) begin
                r_two_rd <= r_one_rd;
            end else begin
                r_two_rd <= r_two_mem[i_rd_addr];
            end
        end
        if (i_two_wr_en) begin
            r_two_mem[i_two_wr_addr] <= r_one_rd;
        end
    end

    assign o_one_rd = r_one_rd;
    assign o_two_rd = r_two_rd;

endmodule

// ===== src/c3z_tap_cell.sv =====
// ---------------------------------------------------------------------------
// c3z_tap_cell
// One window tap: holds a pixel, passes it left, registers its product.
// ---------------------------------------------------------------------------
module c3z_tap_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_shift,
    input  logic [c3z_pkg::PIX_W-1:0]          i_pix,
    input  logic                               i_calc,
    input  logic                               i_zero,
    input  logic [c3z_pkg::COEF_BITS-1:0]      i_coef,
    output logic [c3z_pkg::PIX_W-1:0]          o_pix,
    output logic signed [c3z_pkg::PROD_W-1:0]  o_prod
);

    logic [c3z_pkg::PIX_W-1:0]         r_pix;
    logic signed [c3z_pkg::PROD_W-1:0] r_prod;
    logic signed [c3z_pkg::PROD_W:0]   full_prod;
    logic signed [c3z_pkg::PROD_W-1:0] n_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix <= '0;
        end else if (i_shift) begin
            r_pix <= i_pix;
        end
    end

    // unsigned pixel gets a zero sign bit; result fits PROD_W signed
    always_comb begin
        full_prod = $signed(i_coef) * $signed({1'b0, r_pix});
        n_prod    = i_zero ? '0 : full_prod[c3z_pkg::PROD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_calc) begin
            r_prod <= n_prod;
        end
    end

    assign o_pix  = r_pix;
    assign o_prod = r_prod;

endmodule

// ===== tb/tb_conv3x3_zero_padded.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_conv3x3_zero_padded
// Streams raster frames and drain beats into the 3x3 convolution block with
// random gaps and stalls on both sides. It predicts every filtered sum and
// its row and frame flags, then checks each result beat in order.
// ---------------------------------------------------------------------------
import c3z_pkg::*;

localparam int SAT_HI = 2 ** (FILT_W - 1) - 1;
localparam int SAT_LO = -(2 ** (FILT_W - 1));

// Line stores, window and counters of the block, and the sums still owed.
class conv_scoreboard;
    bit [DIM_W-1:0]  width_reg, height_reg;
    bit [KROW_W-1:0] kernel_row[3];
    bit [PIX_W-1:0]  row_above[MAX_WIDTH];
    bit [PIX_W-1:0]  row_two_above[MAX_WIDTH];
    bit [PIX_W-1:0]  win[3][3];
    int unsigned     in_col, in_row, out_col, out_row;
    t_out_beat       sums_due[$];
    int unsigned     errors;

    function new();
        width_reg     = RST_FRAME_WIDTH;
        height_reg    = RST_FRAME_HEIGHT;
        kernel_row[0] = RST_KROW_TOP;
        kernel_row[1] = RST_KROW_MID;
        kernel_row[2] = RST_KROW_BOTTOM;
        errors        = 0;
        restart();
    endfunction

    function void restart();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function int unsigned clamp_dim(bit [DIM_W-1:0] v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function int unsigned frame_w();
        return clamp_dim(width_reg, MAX_WIDTH);
    endfunction

    function int unsigned frame_h();
        return clamp_dim(height_reg, MAX_HEIGHT);
    endfunction

    function int unsigned pending();
        return sums_due.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_FRAME_WIDTH: begin
                width_reg = data[DIM_W-1:0];
                restart();
            end
            REG_FRAME_HEIGHT: begin
                height_reg = data[DIM_W-1:0];
                restart();
            end
            REG_KROW_TOP:    kernel_row[0] = data[KROW_W-1:0];
            REG_KROW_MID:    kernel_row[1] = data[KROW_W-1:0];
            REG_KROW_BOTTOM: kernel_row[2] = data[KROW_W-1:0];
            default: ;
        endcase
    endfunction

    function void step_in(int unsigned w);
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
    endfunction

    // accepted input beat: shift the window and owe a sum once it is complete
    function void take_beat(t_in_beat b);
        int unsigned                 w, h, c;
        bit [PIX_W-1:0]              v;
        bit [PIX_W-1:0]              prior[3][3];
        bit [PIX_W-1:0]              taps[3][3];
        bit                          started, eor, eof;
        int                          sum;
        logic signed [COEF_BITS-1:0] k;
        t_out_beat                   r;

        w = frame_w();
        h = frame_h();
        v = (b.req_type == REQ_PIXEL) ? b.pixel : '0;
        c = (in_col < MAX_WIDTH) ? in_col : 0;
        started = in_row >= 2 || (in_row == 1 && in_col >= 1);

        prior = win;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = row_two_above[c];
        win[1][2] = row_above[c];
        win[2][2] = v;
        row_two_above[c] = row_above[c];
        row_above[c] = v;

        if (!started) begin
            step_in(w);
            return;
        end

        // last column: the right neighbor is padding, window is one beat ahead
        if (out_col >= w - 1) begin
            for (int i = 0; i < 3; i++) begin
                taps[i][0] = prior[i][1];
                taps[i][1] = prior[i][2];
                taps[i][2] = '0;
            end
        end else begin
            taps = win;
        end
        if (out_col == 0) for (int i = 0; i < 3; i++) taps[i][0] = '0;
        if (out_row == 0) for (int j = 0; j < 3; j++) taps[0][j] = '0;
        if (out_row >= h - 1) for (int j = 0; j < 3; j++) taps[2][j] = '0;

        sum = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                k = kernel_row[i][COEF_BITS*j +: COEF_BITS];
                sum += int'(k) * int'(taps[i][j]);
            end
        end
        if (sum > SAT_HI) sum = SAT_HI;
        if (sum < SAT_LO) sum = SAT_LO;

        eor = out_col >= w - 1;
        eof = eor && out_row >= h - 1;
        r.filtered     = FILT_W'(sum);
        r.end_of_row   = eor;
        r.end_of_frame = eof;
        sums_due.push_back(r);

        if (eof) begin
            restart();
            return;
        end
        if (eor) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
        step_in(w);
    endfunction

    function void match_result(t_out_beat got);
        t_out_beat want;
        if (sums_due.size() == 0) begin
            $error("unexpected result beat: filtered %0d", $signed(got.filtered));
            errors++;
            return;
        end
        want = sums_due.pop_front();
        if (got.filtered !== want.filtered) begin
            $error("filtered: expected %0d, got %0d",
                   $signed(want.filtered), $signed(got.filtered));
            errors++;
        end
        if (got.end_of_row !== want.end_of_row) begin
            $error("end_of_row: expected %0b, got %0b", want.end_of_row, got.end_of_row);
            errors++;
        end
        if (got.end_of_frame !== want.end_of_frame) begin
            $error("end_of_frame: expected %0b, got %0b",
                   want.end_of_frame, got.end_of_frame);
            errors++;
        end
    endfunction
endclass

module tb_conv3x3_zero_padded;

    localparam logic                 REQ_DRAIN    = ~REQ_PIXEL;
    localparam logic [CFG_IDX_W-1:0] REG_NONE     = REG_KROW_BOTTOM + 1'b1;
    localparam int                   RAND_ITEMS   = 1700;
    localparam int                   SETTLE       = 16;
    localparam int                   HOLD_CYCLES  = 300;
    localparam int                   IDLE_PCT     = 17;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_reg_write;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_beat              i_in_beat;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_beat             o_out_beat;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    conv_scoreboard sb;
    t_reg_write     reg_writes[$];
    int unsigned    beats_sent = 0;
    int unsigned    hold_asks = 0;
    bit             steady_in = 1'b0;
    bit             steady_out = 1'b0;

    conv3x3_zero_padded dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.match_result(o_out_beat);
        end
    end

    // called at a falling edge; returns at a falling edge with valid low
    task automatic send_stream(input t_in_beat beats[$]);
        foreach (beats[n]) begin
            if (!steady_in && $urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                do @(negedge i_clk); while ($urandom_range(99) < IDLE_PCT);
            end
            i_in_valid <= 1'b1;
            i_in_beat  <= beats[n];
            do @(posedge i_clk); while (o_in_stall);
            sb.take_beat(beats[n]);
            beats_sent++;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic load_regs();
        t_reg_write wr;
        while (reg_writes.size() != 0) begin
            wr = reg_writes.pop_front();
            i_cfg_valid <= 1'b1;
            i_cfg_index <= wr.idx;
            i_cfg_data  <= wr.data;
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_reg(wr.idx, wr.data);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // beats that start no sum may still be in flight after the last result
    task automatic wait_quiet();
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic void add_frame(ref t_in_beat q[$], input int unsigned w, h, noise_pct);
        t_in_beat b;
        for (int n = 0; n < w * h + w + 1; n++) begin
            b.pixel    = PIX_W'($urandom);
            b.req_type = (n < w * h) ? REQ_PIXEL : REQ_DRAIN;
            if ($urandom_range(99) < noise_pct) b.req_type = ~b.req_type;
            q.push_back(b);
        end
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim(int unsigned hi);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 6) return '0;
        if (r < 70) return DIM_W'($urandom_range(4, 1));
        return DIM_W'($urandom_range(hi, 1));
    endfunction

    function automatic logic [KROW_W-1:0] pick_kernel();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return 24'h808080;
        if (r < 20) return 24'h7F7F7F;
        if (r < 25) return '0;
        return KROW_W'($urandom);
    endfunction

    initial begin : stimulus
        t_in_beat    beats[$];
        int unsigned base, rand_sent, r, cut;
        bit          pressed, need_restart;

        sb = new;
        pressed = 1'b0;
        need_restart = 1'b1;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_beat   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // small frame, extreme coefficients, misplaced drain and pixel beats
        reg_writes.push_back('{REG_FRAME_WIDTH, 24'd3});
        reg_writes.push_back('{REG_FRAME_HEIGHT, 24'd2});
        reg_writes.push_back('{REG_KROW_TOP, 24'h7F80FF});
        reg_writes.push_back('{REG_KROW_MID, 24'h010203});
        reg_writes.push_back('{REG_KROW_BOTTOM, 24'h80007F});
        reg_writes.push_back('{REG_NONE, 24'hFFFFFF});
        load_regs();
        beats = '{'{REQ_PIXEL, 8'd255}, '{REQ_PIXEL, 8'd0}, '{REQ_PIXEL, 8'd255},
                  '{REQ_PIXEL, 8'd128}, '{REQ_DRAIN, 8'd255}, '{REQ_PIXEL, 8'd1},
                  '{REQ_DRAIN, 8'd0}, '{REQ_PIXEL, 8'd170}, '{REQ_DRAIN, 8'd255},
                  '{REQ_DRAIN, 8'd0}};
        send_stream(beats);

        // zero geometry clamps to a single pixel; upper data bits are ignored
        wait_quiet();
        reg_writes.push_back('{REG_FRAME_WIDTH, 24'hFFF800});
        reg_writes.push_back('{REG_FRAME_HEIGHT, 24'h000000});
        reg_writes.push_back('{REG_KROW_TOP, 24'h808080});
        reg_writes.push_back('{REG_KROW_MID, 24'h808080});
        reg_writes.push_back('{REG_KROW_BOTTOM, 24'h808080});
        load_regs();
        beats = '{'{REQ_PIXEL, 8'd255}, '{REQ_DRAIN, 8'd0}, '{REQ_DRAIN, 8'd255}};
        send_stream(beats);

        // full-scale negative sum at the center pixel
        wait_quiet();
        reg_writes.push_back('{REG_FRAME_WIDTH, 24'd3});
        reg_writes.push_back('{REG_FRAME_HEIGHT, 24'd3});
        load_regs();
        beats.delete();
        repeat (9) beats.push_back('{REQ_PIXEL, 8'd255});
        repeat (4) beats.push_back('{REQ_DRAIN, 8'd0});
        send_stream(beats);

        // widest single row, then tallest single column
        wait_quiet();
        reg_writes.push_back('{REG_FRAME_WIDTH, 24'h0007FF});
        reg_writes.push_back('{REG_FRAME_HEIGHT, 24'd1});
        reg_writes.push_back('{REG_KROW_TOP, pick_kernel()});
        reg_writes.push_back('{REG_KROW_MID, pick_kernel()});
        reg_writes.push_back('{REG_KROW_BOTTOM, pick_kernel()});
        load_regs();
        beats.delete();
        add_frame(beats, sb.frame_w(), sb.frame_h(), 0);
        send_stream(beats);

        wait_quiet();
        reg_writes.push_back('{REG_FRAME_WIDTH, 24'd1});
        reg_writes.push_back('{REG_FRAME_HEIGHT, 24'h0007FF});
        reg_writes.push_back('{REG_KROW_MID, pick_kernel()});
        load_regs();
        beats.delete();
        add_frame(beats, sb.frame_w(), sb.frame_h(), 0);
        send_stream(beats);

        // random frames; cut or overlong ones are followed by a geometry restart
        base = beats_sent;
        rand_sent = 0;
        while (rand_sent < RAND_ITEMS) begin
            steady_in  = rand_sent >= 600 && rand_sent < 900;
            steady_out = rand_sent >= 750 && rand_sent < 1100;
            wait_quiet();
            if ($urandom_range(1) == 0) reg_writes.push_back('{REG_KROW_TOP, pick_kernel()});
            if ($urandom_range(1) == 0) reg_writes.push_back('{REG_KROW_MID, pick_kernel()});
            if ($urandom_range(1) == 0) reg_writes.push_back('{REG_KROW_BOTTOM, pick_kernel()});
            if ($urandom_range(7) == 0) begin
                reg_writes.push_back('{REG_NONE + CFG_IDX_W'($urandom_range(2)),
                                       CFG_DATA_W'($urandom)});
            end
            if (need_restart || $urandom_range(2) == 0) begin
                reg_writes.push_back('{REG_FRAME_WIDTH, {13'($urandom), pick_dim(40)}});
                reg_writes.push_back('{REG_FRAME_HEIGHT, {13'($urandom), pick_dim(6)}});
                need_restart = 1'b0;
            end
            load_regs();

            beats.delete();
            add_frame(beats, sb.frame_w(), sb.frame_h(), ($urandom_range(3) == 0) ? 3 : 0);
            r = $urandom_range(9);
            if (r == 0 && beats.size() > 1) begin
                cut = $urandom_range(beats.size() - 1, 1);
                repeat (cut) void'(beats.pop_back());
                need_restart = 1'b1;
            end else if (r == 1) begin
                repeat ($urandom_range(5, 1)) beats.push_back(t_in_beat'($urandom));
                need_restart = 1'b1;
            end

            // hold off only on a whole frame with enough sums to back the block up
            if (!pressed && rand_sent >= 300 && r != 0 &&
                sb.frame_w() * sb.frame_h() >= 8) begin
                pressed = 1'b1;
                hold_asks++;
            end
            send_stream(beats);
            rand_sent = beats_sent - base;
        end

        wait_quiet();
        if (sb.errors == 0) begin
            $display("PASS conv3x3_zero_padded");
        end else begin
            $display("FAIL conv3x3_zero_padded");
        end
        $finish;
    end

    initial begin : result_side
        int unsigned held;
        int unsigned holds_done;
        holds_done  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            // long hold-off so the block backs up and stalls its input
            if (holds_done != hold_asks) begin
                holds_done++;
                i_out_stall <= 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++) @(negedge i_clk);
            end
            i_out_stall <= !steady_out && $urandom_range(99) < IDLE_PCT;
        end
    end

    initial begin : watchdog
        #(2_000_000);
        $display("FAIL conv3x3_zero_padded");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/c3z_pkg.sv
src/c3z_line_store.sv
src/c3z_tap_cell.sv
src/conv3x3_zero_padded.sv
tb/tb_conv3x3_zero_padded.sv
